@@ sv/assert_macros.svh @@
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is high
`define ASSERT_CLK(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("grid laplacian check failed");

// clocked assertion that also holds through reset
`define ASSERT_CLK_NR(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("grid laplacian check failed");

`endif

@@ sv/gl7_pkg.sv @@
// shared types and constants of the seven-point laplacian grid block
package gl7_pkg;

   // field widths
   localparam int DATA_BITS      = 32;
   localparam int POS_BITS       = 5;
   localparam int EXT_BITS       = 5;
   localparam int INV_BITS       = 32;
   localparam int OP_BITS        = 2;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 32;

   // grid geometry
   localparam int MAX_EXTENT = 30;
   localparam int SIDE       = MAX_EXTENT + 2;
   localparam int CELLS      = SIDE * SIDE * SIDE;
   localparam int ADDR_BITS  = $clog2(CELLS);

   // reset values of the control registers
   localparam int          EXTENT_RESET = 30;
   localparam logic [31:0] INV_RESET    = 32'd65536;

   // arithmetic widths
   localparam int VALUE_BITS = 32;
   localparam int SAT_BITS   = (VALUE_BITS < DATA_BITS) ? VALUE_BITS : DATA_BITS;
   localparam int DIFF_BITS  = DATA_BITS + 2;
   localparam int HALF_BITS  = INV_BITS / 2;
   localparam int PROD_BITS  = DIFF_BITS + HALF_BITS + 1;
   localparam int ACC_BITS   = PROD_BITS + 2;

   // clamp bounds of the laplacian sum
   localparam logic signed [ACC_BITS-1:0] SAT_HI =
      {{(ACC_BITS - SAT_BITS + 1){1'b0}}, {(SAT_BITS - 1){1'b1}}};
   localparam logic signed [ACC_BITS-1:0] SAT_LO = ~SAT_HI;

   // multiply steps of one laplacian: two halves per axis
   localparam int SLOT_BITS    = 3;
   localparam int MUL_STEPS    = 6;
   localparam int MUL_CNT_BITS = 3;

   typedef enum logic [OP_BITS-1:0] {
      OP_WRITE   = 2'd0,
      OP_READ    = 2'd1,
      OP_LAPLACE = 2'd2
   } opcode_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_EXTENT_X = 3'd0,
      CSR_EXTENT_Y = 3'd1,
      CSR_EXTENT_Z = 3'd2,
      CSR_INV_X    = 3'd3,
      CSR_INV_Y    = 3'd4,
      CSR_INV_Z    = 3'd5
   } csr_index_type;

   // order in which the stencil cells are read
   typedef enum logic [SLOT_BITS-1:0] {
      SLOT_C  = 3'd0,
      SLOT_XL = 3'd1,
      SLOT_XR = 3'd2,
      SLOT_YL = 3'd3,
      SLOT_YR = 3'd4,
      SLOT_ZL = 3'd5,
      SLOT_ZR = 3'd6
   } slot_type;

   typedef enum logic [1:0] {
      AXIS_X = 2'd0,
      AXIS_Y = 2'd1,
      AXIS_Z = 2'd2
   } axis_type;

   // single port memory request
   typedef struct packed {
      logic                 en;
      logic                 we;
      logic [ADDR_BITS-1:0] addr;
      logic [DATA_BITS-1:0] wdata;
   } mem_req_type;

   // sequencer controls of the stencil unit
   typedef struct packed {
      logic     start;
      logic     data_valid;
      slot_type data_slot;
      logic     mul_en;
      axis_type mul_axis;
      logic     mul_hi;
   } alu_ctrl_type;

endpackage

@@ sv/gl7_grid_mem.sv @@
// single port grid store with registered read data
module gl7_grid_mem (
   input  logic                          clock,
   input  gl7_pkg::mem_req_type          mem_req,
   output logic [gl7_pkg::DATA_BITS-1:0] rd_data
);
   import gl7_pkg::*;

   logic [DATA_BITS-1:0] store_ff [CELLS];
   logic [DATA_BITS-1:0] rd_data_ff;

   // one access a cycle; read data holds until the next read
   always_ff @(posedge clock) begin
      if (mem_req.en) begin
         if (mem_req.we) begin
            store_ff[mem_req.addr] <= mem_req.wdata;
         end else begin
            rd_data_ff <= store_ff[mem_req.addr];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/gl7_stencil_alu.sv @@
// second differences, shared multiplier and accumulator of the laplacian
module gl7_stencil_alu (
   input  logic                          clock,
   input  logic                          reset,
   input  gl7_pkg::alu_ctrl_type         ctrl,
   input  logic [gl7_pkg::DATA_BITS-1:0] rd_data,
   input  logic [gl7_pkg::INV_BITS-1:0]  inv_x,
   input  logic [gl7_pkg::INV_BITS-1:0]  inv_y,
   input  logic [gl7_pkg::INV_BITS-1:0]  inv_z,
   output logic [gl7_pkg::DATA_BITS-1:0] lap_value,
   output logic                          lap_sat
);
   import gl7_pkg::*;

   localparam logic signed [PROD_BITS:0] ROUND_BIAS =
      (PROD_BITS + 1)'(1) <<< (HALF_BITS - 1);

   logic signed [DIFF_BITS-1:0] nb;
   logic signed [DIFF_BITS-1:0] neg_c2_ff, neg_c2_in;
   logic signed [DIFF_BITS-1:0] dx_ff, dx_in;
   logic signed [DIFF_BITS-1:0] dy_ff, dy_in;
   logic signed [DIFF_BITS-1:0] dz_ff, dz_in;
   logic signed [DIFF_BITS-1:0] diff_prev;
   logic signed [DIFF_BITS-1:0] diff_sum;
   logic                        diff_first;

   logic signed [DIFF_BITS-1:0] mul_d;
   logic [INV_BITS-1:0]         mul_inv;
   logic signed [HALF_BITS:0]   mul_k;
   logic signed [PROD_BITS-1:0] prod_ff, prod_in;
   logic                        prod_valid_ff;
   logic                        prod_hi_ff;

   logic signed [PROD_BITS:0]   prod_round;
   logic signed [PROD_BITS:0]   lo_term;
   logic signed [ACC_BITS-1:0]  acc_add;
   logic signed [ACC_BITS-1:0]  acc_ff, acc_in;
   logic signed [ACC_BITS-1:0]  clamped;

   // neighbor value widened to the difference width
   assign nb = {{(DIFF_BITS - DATA_BITS){rd_data[DATA_BITS-1]}}, rd_data};

   // the left neighbor of an axis starts from minus twice the center
   always_comb begin
      diff_first = 1'b0;
      diff_prev  = dx_ff;
      case (ctrl.data_slot)
         SLOT_XL: diff_first = 1'b1;
         SLOT_XR: diff_prev  = dx_ff;
         SLOT_YL: diff_first = 1'b1;
         SLOT_YR: diff_prev  = dy_ff;
         SLOT_ZL: diff_first = 1'b1;
         SLOT_ZR: diff_prev  = dz_ff;
         default: diff_prev  = dx_ff;
      endcase
   end

   assign diff_sum = nb + (diff_first ? neg_c2_ff : diff_prev);

   // one difference update per arriving beat of read data
   always_comb begin
      neg_c2_in = neg_c2_ff;
      dx_in     = dx_ff;
      dy_in     = dy_ff;
      dz_in     = dz_ff;
      if (ctrl.data_valid) begin
         case (ctrl.data_slot)
            SLOT_C:           neg_c2_in = -(nb <<< 1);
            SLOT_XL, SLOT_XR: dx_in     = diff_sum;
            SLOT_YL, SLOT_YR: dy_in     = diff_sum;
            SLOT_ZL, SLOT_ZR: dz_in     = diff_sum;
            default:          neg_c2_in = neg_c2_ff;
         endcase
      end
   end

   // shared multiplier: difference times one 16-bit half of the spacing term
   always_comb begin
      case (ctrl.mul_axis)
         AXIS_X: begin
            mul_d   = dx_ff;
            mul_inv = inv_x;
         end
         AXIS_Y: begin
            mul_d   = dy_ff;
            mul_inv = inv_y;
         end
         AXIS_Z: begin
            mul_d   = dz_ff;
            mul_inv = inv_z;
         end
         default: begin
            mul_d   = dx_ff;
            mul_inv = inv_x;
         end
      endcase
   end

   assign mul_k   = ctrl.mul_hi ? signed'({1'b0, mul_inv[INV_BITS-1:HALF_BITS]})
                                : signed'({1'b0, mul_inv[HALF_BITS-1:0]});
   assign prod_in = mul_d * mul_k;

   // low half rounds to nearest with ties up, high half adds as it is
   assign prod_round = (PROD_BITS + 1)'(prod_ff) + ROUND_BIAS;
   assign lo_term    = prod_round >>> HALF_BITS;
   assign acc_add    = prod_hi_ff ? ACC_BITS'(prod_ff) : ACC_BITS'(lo_term);

   always_comb begin
      acc_in = acc_ff;
      if (ctrl.start) begin
         acc_in = '0;
      end else if (prod_valid_ff) begin
         acc_in = acc_ff + acc_add;
      end
   end

   // clamp the finished sum
   always_comb begin
      lap_sat = 1'b0;
      clamped = acc_ff;
      if (acc_ff > SAT_HI) begin
         clamped = SAT_HI;
         lap_sat = 1'b1;
      end else if (acc_ff < SAT_LO) begin
         clamped = SAT_LO;
         lap_sat = 1'b1;
      end
   end

   assign lap_value = clamped[DATA_BITS-1:0];

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
      end else begin
         prod_valid_ff <= ctrl.mul_en;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      neg_c2_ff  <= neg_c2_in;
      dx_ff      <= dx_in;
      dy_ff      <= dy_in;
      dz_ff      <= dz_in;
      prod_ff    <= prod_in;
      prod_hi_ff <= ctrl.mul_hi;
      acc_ff     <= acc_in;
   end

endmodule

@@ sv/grid_laplacian_7pt.sv @@
// top level of the seven-point laplacian grid block
//
// Holds a 32x32x32 grid of signed Q16.16 cells (halo included) in one
// single-port memory and serves write, read and laplacian requests one at a
// time. After reset the block runs a clearing pass, one cell a cycle, and
// stalls requests until it ends; control register writes are taken
// throughout. The result of a write, an unknown opcode or a rejected index
// is registered from the index check state, a read from the read wait
// state that follows it, and a laplacian after the index check, seven cell
// reads through the memory port, six passes through the shared 34x17
// multiplier (two halves of the spacing term per axis), one accumulate and
// one clamp. The next request is taken in the cycle after its result is
// registered; a finished result that finds the earlier one still stalled
// waits in its last state until the response side frees.
module grid_laplacian_7pt (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [gl7_pkg::OP_BITS-1:0]        req_opcode,
   input  logic [gl7_pkg::POS_BITS-1:0]       req_pos_x,
   input  logic [gl7_pkg::POS_BITS-1:0]       req_pos_y,
   input  logic [gl7_pkg::POS_BITS-1:0]       req_pos_z,
   input  logic signed [gl7_pkg::DATA_BITS-1:0] req_write_value,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [gl7_pkg::DATA_BITS-1:0] rsp_result_value,
   output logic                               rsp_bad_index,
   output logic                               rsp_saturated,
   input  logic                               csr_write_enable,
   input  logic [gl7_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [gl7_pkg::CSR_DATA_BITS-1:0]  csr_data
);
   import gl7_pkg::*;

   typedef enum logic [7:0] {
      S_CLEAR = 8'b0000_0001,
      S_IDLE  = 8'b0000_0010,
      S_EXEC  = 8'b0000_0100,
      S_READW = 8'b0000_1000,
      S_LREAD = 8'b0001_0000,
      S_LMUL  = 8'b0010_0000,
      S_LACC  = 8'b0100_0000,
      S_LFIN  = 8'b1000_0000
   } state_type;

   state_type                state_ff, state_in;
   logic [ADDR_BITS-1:0]     clr_cnt_ff, clr_cnt_in;
   logic [SLOT_BITS-1:0]     rd_cnt_ff, rd_cnt_in;
   logic [MUL_CNT_BITS-1:0]  mul_cnt_ff, mul_cnt_in;
   logic                     rd_slot_valid_ff;
   slot_type                 rd_slot_ff;

   logic [OP_BITS-1:0]       op_ff, op_in;
   logic [POS_BITS-1:0]      px_ff, px_in;
   logic [POS_BITS-1:0]      py_ff, py_in;
   logic [POS_BITS-1:0]      pz_ff, pz_in;
   logic [DATA_BITS-1:0]     wval_ff, wval_in;

   logic [EXT_BITS-1:0]      ext_x_ff, ext_x_in;
   logic [EXT_BITS-1:0]      ext_y_ff, ext_y_in;
   logic [EXT_BITS-1:0]      ext_z_ff, ext_z_in;
   logic [INV_BITS-1:0]      inv_x_ff, inv_x_in;
   logic [INV_BITS-1:0]      inv_y_ff, inv_y_in;
   logic [INV_BITS-1:0]      inv_z_ff, inv_z_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [DATA_BITS-1:0]     rsp_value_ff;
   logic                     rsp_bad_ff;
   logic                     rsp_sat_ff;

   logic                     out_free;
   logic                     load_rsp;
   logic [DATA_BITS-1:0]     load_value;
   logic                     load_bad;
   logic                     load_sat;
   logic                     alu_start;

   logic [EXT_BITS-1:0]      ex, ey, ez;
   logic                     in_grid;
   logic                     interior;
   logic [POS_BITS-1:0]      rx, ry, rz;

   mem_req_type              mem_req;
   logic [DATA_BITS-1:0]     mem_rd_data;
   alu_ctrl_type             alu_ctrl;
   logic [DATA_BITS-1:0]     lap_value;
   logic                     lap_sat;

   function automatic logic [EXT_BITS-1:0] eff_extent(input logic [EXT_BITS-1:0] e);
      return (e > EXT_BITS'(MAX_EXTENT)) ? EXT_BITS'(MAX_EXTENT) : e;
   endfunction

   function automatic logic [ADDR_BITS-1:0] cell_addr(input logic [POS_BITS-1:0] x,
                                                      input logic [POS_BITS-1:0] y,
                                                      input logic [POS_BITS-1:0] z);
      return ADDR_BITS'(ADDR_BITS'(x) * ADDR_BITS'(SIDE * SIDE)
                        + ADDR_BITS'(y) * ADDR_BITS'(SIDE) + ADDR_BITS'(z));
   endfunction

   // index checks against the clamped extents
   assign ex = eff_extent(ext_x_ff);
   assign ey = eff_extent(ext_y_ff);
   assign ez = eff_extent(ext_z_ff);

   assign in_grid =
      ((EXT_BITS + 1)'(px_ff) <= (EXT_BITS + 1)'(ex) + (EXT_BITS + 1)'(1)) &&
      ((EXT_BITS + 1)'(py_ff) <= (EXT_BITS + 1)'(ey) + (EXT_BITS + 1)'(1)) &&
      ((EXT_BITS + 1)'(pz_ff) <= (EXT_BITS + 1)'(ez) + (EXT_BITS + 1)'(1));

   assign interior =
      (px_ff != '0) && (EXT_BITS'(px_ff) <= ex) &&
      (py_ff != '0) && (EXT_BITS'(py_ff) <= ey) &&
      (pz_ff != '0) && (EXT_BITS'(pz_ff) <= ez);

   // result register can take a beat
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);

   // stencil cell of the current read slot
   always_comb begin
      rx = px_ff;
      ry = py_ff;
      rz = pz_ff;
      case (slot_type'(rd_cnt_ff))
         SLOT_XL: rx = px_ff - POS_BITS'(1);
         SLOT_XR: rx = px_ff + POS_BITS'(1);
         SLOT_YL: ry = py_ff - POS_BITS'(1);
         SLOT_YR: ry = py_ff + POS_BITS'(1);
         SLOT_ZL: rz = pz_ff - POS_BITS'(1);
         SLOT_ZR: rz = pz_ff + POS_BITS'(1);
         default: rx = px_ff;
      endcase
   end

   // sequencer
   always_comb begin
      state_in   = state_ff;
      clr_cnt_in = clr_cnt_ff;
      rd_cnt_in  = rd_cnt_ff;
      mul_cnt_in = mul_cnt_ff;
      op_in      = op_ff;
      px_in      = px_ff;
      py_in      = py_ff;
      pz_in      = pz_ff;
      wval_in    = wval_ff;
      load_rsp   = 1'b0;
      load_value = '0;
      load_bad   = 1'b0;
      load_sat   = 1'b0;
      alu_start  = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + ADDR_BITS'(1);
            if (clr_cnt_ff == ADDR_BITS'(CELLS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               op_in    = req_opcode;
               px_in    = req_pos_x;
               py_in    = req_pos_y;
               pz_in    = req_pos_z;
               wval_in  = req_write_value;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            case (opcode_type'(op_ff))
               OP_WRITE: begin
                  if (out_free) begin
                     load_rsp = 1'b1;
                     load_bad = !in_grid;
                     state_in = S_IDLE;
                  end
               end
               OP_READ: begin
                  if (in_grid) begin
                     state_in = S_READW;
                  end else if (out_free) begin
                     load_rsp = 1'b1;
                     load_bad = 1'b1;
                     state_in = S_IDLE;
                  end
               end
               OP_LAPLACE: begin
                  if (interior) begin
                     alu_start = 1'b1;
                     rd_cnt_in = '0;
                     state_in  = S_LREAD;
                  end else if (out_free) begin
                     load_rsp = 1'b1;
                     load_bad = 1'b1;
                     state_in = S_IDLE;
                  end
               end
               default: begin
                  if (out_free) begin
                     load_rsp = 1'b1;
                     state_in = S_IDLE;
                  end
               end
            endcase
         end
         S_READW: begin
            if (out_free) begin
               load_rsp   = 1'b1;
               load_value = mem_rd_data;
               state_in   = S_IDLE;
            end
         end
         S_LREAD: begin
            rd_cnt_in = rd_cnt_ff + SLOT_BITS'(1);
            if (slot_type'(rd_cnt_ff) == SLOT_ZR) begin
               mul_cnt_in = '0;
               state_in   = S_LMUL;
            end
         end
         S_LMUL: begin
            mul_cnt_in = mul_cnt_ff + MUL_CNT_BITS'(1);
            if (mul_cnt_ff == MUL_CNT_BITS'(MUL_STEPS - 1)) begin
               state_in = S_LACC;
            end
         end
         S_LACC: begin
            state_in = S_LFIN;
         end
         S_LFIN: begin
            if (out_free) begin
               load_rsp   = 1'b1;
               load_value = lap_value;
               load_sat   = lap_sat;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   // memory port: clearing pass, single accesses, stencil reads
   always_comb begin
      mem_req = '0;
      case (state_ff)
         S_CLEAR: begin
            mem_req.en   = 1'b1;
            mem_req.we   = 1'b1;
            mem_req.addr = clr_cnt_ff;
         end
         S_EXEC: begin
            mem_req.addr  = cell_addr(px_ff, py_ff, pz_ff);
            mem_req.wdata = wval_ff;
            if (opcode_type'(op_ff) == OP_WRITE) begin
               mem_req.en = in_grid && out_free;
               mem_req.we = 1'b1;
            end else if (opcode_type'(op_ff) == OP_READ) begin
               mem_req.en = in_grid;
            end
         end
         S_LREAD: begin
            mem_req.en   = 1'b1;
            mem_req.addr = cell_addr(rx, ry, rz);
         end
         default: begin
            mem_req.en = 1'b0;
         end
      endcase
   end

   // control register writes
   always_comb begin
      ext_x_in = ext_x_ff;
      ext_y_in = ext_y_ff;
      ext_z_in = ext_z_ff;
      inv_x_in = inv_x_ff;
      inv_y_in = inv_y_ff;
      inv_z_in = inv_z_ff;
      if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_EXTENT_X: ext_x_in = csr_data[EXT_BITS-1:0];
            CSR_EXTENT_Y: ext_y_in = csr_data[EXT_BITS-1:0];
            CSR_EXTENT_Z: ext_z_in = csr_data[EXT_BITS-1:0];
            CSR_INV_X:    inv_x_in = csr_data[INV_BITS-1:0];
            CSR_INV_Y:    inv_y_in = csr_data[INV_BITS-1:0];
            CSR_INV_Z:    inv_z_in = csr_data[INV_BITS-1:0];
            default:      ext_x_in = ext_x_ff;
         endcase
      end
   end

   // response beat holds while stalled
   assign rsp_valid_in = load_rsp || (rsp_valid_ff && rsp_stall);

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_CLEAR;
         clr_cnt_ff       <= '0;
         rd_cnt_ff        <= '0;
         mul_cnt_ff       <= '0;
         rd_slot_valid_ff <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         ext_x_ff         <= EXT_BITS'(EXTENT_RESET);
         ext_y_ff         <= EXT_BITS'(EXTENT_RESET);
         ext_z_ff         <= EXT_BITS'(EXTENT_RESET);
         inv_x_ff         <= INV_RESET;
         inv_y_ff         <= INV_RESET;
         inv_z_ff         <= INV_RESET;
      end else begin
         state_ff         <= state_in;
         clr_cnt_ff       <= clr_cnt_in;
         rd_cnt_ff        <= rd_cnt_in;
         mul_cnt_ff       <= mul_cnt_in;
         rd_slot_valid_ff <= (state_ff == S_LREAD);
         rsp_valid_ff     <= rsp_valid_in;
         ext_x_ff         <= ext_x_in;
         ext_y_ff         <= ext_y_in;
         ext_z_ff         <= ext_z_in;
         inv_x_ff         <= inv_x_in;
         inv_y_ff         <= inv_y_in;
         inv_z_ff         <= inv_z_in;
      end
   end

   // request and response payload
   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      px_ff      <= px_in;
      py_ff      <= py_in;
      pz_ff      <= pz_in;
      wval_ff    <= wval_in;
      rd_slot_ff <= slot_type'(rd_cnt_ff);
      if (load_rsp) begin
         rsp_value_ff <= load_value;
         rsp_bad_ff   <= load_bad;
         rsp_sat_ff   <= load_sat;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = signed'(rsp_value_ff);
   assign rsp_bad_index    = rsp_bad_ff;
   assign rsp_saturated    = rsp_sat_ff;

   // stencil unit controls, read data lines up in the cycle after its address
   assign alu_ctrl.start      = alu_start;
   assign alu_ctrl.data_valid = rd_slot_valid_ff;
   assign alu_ctrl.data_slot  = rd_slot_ff;
   assign alu_ctrl.mul_en     = (state_ff == S_LMUL);
   assign alu_ctrl.mul_axis   = axis_type'(mul_cnt_ff[MUL_CNT_BITS-1:1]);
   assign alu_ctrl.mul_hi     = mul_cnt_ff[0];

   gl7_grid_mem u_grid_mem (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (mem_rd_data)
   );

   gl7_stencil_alu u_stencil_alu (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (alu_ctrl),
      .rd_data   (mem_rd_data),
      .inv_x     (inv_x_ff),
      .inv_y     (inv_y_ff),
      .inv_z     (inv_z_ff),
      .lap_value (lap_value),
      .lap_sat   (lap_sat)
   );

endmodule

@@ sv/gl7_checker.sv @@
// port-level assertions of the laplacian grid block and their bind
`include "assert_macros.svh"

module gl7_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_stall,
   input logic                                 rsp_valid,
   input logic                                 rsp_stall,
   input logic signed [gl7_pkg::DATA_BITS-1:0] rsp_result_value,
   input logic                                 rsp_bad_index,
   input logic                                 rsp_saturated
);
   import gl7_pkg::*;

   localparam logic [DATA_BITS-1:0] CLAMP_HI = SAT_HI[DATA_BITS-1:0];
   localparam logic [DATA_BITS-1:0] CLAMP_LO = SAT_LO[DATA_BITS-1:0];

   // stalled response beat holds
   property p_rsp_hold;
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_result_value) &&
         $stable(rsp_bad_index) && $stable(rsp_saturated);
   endproperty

   // one request at a time: busy right after an accepted beat
   property p_busy_after_accept;
      req_valid && !req_stall |=> req_stall;
   endproperty

   // clearing pass holds off requests after reset
   property p_clear_after_reset;
      reset |=> req_stall;
   endproperty

   // a clamped sum is a good index and sits at a range bound
   property p_sat_clamped;
      rsp_valid && rsp_saturated |-> !rsp_bad_index &&
         (rsp_result_value == CLAMP_HI || rsp_result_value == CLAMP_LO);
   endproperty

   // a new response only comes out of a busy cycle
   property p_rsp_from_busy;
      $rose(rsp_valid) |-> $past(req_stall);
   endproperty

   `ASSERT_CLK(a_rsp_hold, clock, reset, p_rsp_hold)
   `ASSERT_CLK(a_busy_after_accept, clock, reset, p_busy_after_accept)
   `ASSERT_CLK_NR(a_clear_after_reset, clock, p_clear_after_reset)
   `ASSERT_CLK(a_sat_clamped, clock, reset, p_sat_clamped)
   `ASSERT_CLK(a_rsp_from_busy, clock, reset, p_rsp_from_busy)

endmodule

bind grid_laplacian_7pt gl7_checker u_gl7_checker (.*);

@@ verif/tb_grid_laplacian_7pt.sv @@
`timescale 1ns / 100ps
// self-checking testbench for the seven-point laplacian grid block
module tb_grid_laplacian_7pt;
   import gl7_pkg::*;

   localparam logic [OP_BITS-1:0] OP_SPARE  = 2'd3;
   localparam int CYCLE_LIMIT              = 1200000;
   localparam int DRAIN_CYCLES             = 40;
   localparam int PHASE_ITEMS              = 165;
   localparam int WIDE                     = 80;
   localparam logic signed [WIDE-1:0] VALUE_MAX = 80'sd2147483647;
   localparam logic signed [WIDE-1:0] VALUE_MIN = -80'sd2147483648;

   typedef struct {
      logic signed [DATA_BITS-1:0] value;
      logic                        bad;
      logic                        sat;
   } grid_response_type;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_valid = 1'b0;
   logic                              req_stall;
   logic [OP_BITS-1:0]                req_opcode = '0;
   logic [POS_BITS-1:0]               req_pos_x = '0;
   logic [POS_BITS-1:0]               req_pos_y = '0;
   logic [POS_BITS-1:0]               req_pos_z = '0;
   logic signed [DATA_BITS-1:0]       req_write_value = '0;
   logic                              rsp_valid;
   logic                              rsp_stall = 1'b0;
   logic signed [DATA_BITS-1:0]       rsp_result_value;
   logic                              rsp_bad_index;
   logic                              rsp_saturated;
   logic                              csr_write_enable = 1'b0;
   logic [CSR_INDEX_BITS-1:0]         csr_index = '0;
   logic [CSR_DATA_BITS-1:0]          csr_data = '0;

   // local copy of the grid and the control registers
   logic signed [DATA_BITS-1:0] grid_model [CELLS];
   logic [EXT_BITS-1:0]         cfg_extent [3];
   logic [INV_BITS-1:0]         cfg_inv [3];

   grid_response_type pending_responses [$];
   int             error_count = 0;
   int             cycle_count = 0;
   int             stall_left = 0;
   bit             req_gaps_on = 1'b1;
   bit             rsp_stalls_on = 1'b1;

   grid_laplacian_7pt dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_opcode       (req_opcode),
      .req_pos_x        (req_pos_x),
      .req_pos_y        (req_pos_y),
      .req_pos_z        (req_pos_z),
      .req_write_value  (req_write_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result_value (rsp_result_value),
      .rsp_bad_index    (rsp_bad_index),
      .rsp_saturated    (rsp_saturated),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   // clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("tb_grid_laplacian_7pt: done, errors");
      $finish;
   end

   // idle length: mostly none or short, now and then long
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      if (roll < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic int clamp_extent(logic [EXT_BITS-1:0] ext);
      return (ext > MAX_EXTENT) ? MAX_EXTENT : int'(ext);
   endfunction

   function automatic int cell_index(int x, int y, int z);
      return (x * SIDE + y) * SIDE + z;
   endfunction

   function automatic logic signed [WIDE-1:0] cell_at(int x, int y, int z);
      return WIDE'(grid_model[cell_index(x, y, z)]);
   endfunction

   // second difference times unsigned Q16.16 spacing term, rounded half up
   function automatic logic signed [WIDE-1:0] scaled_term(logic signed [WIDE-1:0] diff,
                                                        logic [INV_BITS-1:0] inv);
      logic signed [WIDE-1:0] prod;
      prod = diff * $signed({48'd0, inv});
      return (prod + 80'sd32768) >>> 16;
   endfunction

   function automatic void clear_grid_model();
      foreach (grid_model[i]) grid_model[i] = '0;
      foreach (cfg_extent[a]) begin
         cfg_extent[a] = EXTENT_RESET[EXT_BITS-1:0];
         cfg_inv[a]    = INV_RESET;
      end
   endfunction

   // expected result of one request, updating the grid copy on writes
   function automatic grid_response_type compute_response(logic [OP_BITS-1:0] op,
                                                       logic [POS_BITS-1:0] x,
                                                       logic [POS_BITS-1:0] y,
                                                       logic [POS_BITS-1:0] z,
                                                       logic signed [DATA_BITS-1:0] wv);
      grid_response_type r;
      int ex, ey, ez;
      bit in_grid, interior;
      logic signed [WIDE-1:0] c2, dx, dy, dz, total;
      r.value = '0;
      r.bad   = 1'b0;
      r.sat   = 1'b0;
      ex = clamp_extent(cfg_extent[0]);
      ey = clamp_extent(cfg_extent[1]);
      ez = clamp_extent(cfg_extent[2]);
      in_grid  = x <= ex + 1 && y <= ey + 1 && z <= ez + 1;
      interior = x >= 1 && x <= ex && y >= 1 && y <= ey && z >= 1 && z <= ez;
      case (op)
         OP_WRITE: begin
            if (in_grid) grid_model[cell_index(x, y, z)] = wv;
            else r.bad = 1'b1;
         end
         OP_READ: begin
            if (in_grid) r.value = grid_model[cell_index(x, y, z)];
            else r.bad = 1'b1;
         end
         OP_LAPLACE: begin
            if (!interior) begin
               r.bad = 1'b1;
            end else begin
               c2 = cell_at(x, y, z) * 2;
               dx = cell_at(x - 1, y, z) - c2 + cell_at(x + 1, y, z);
               dy = cell_at(x, y - 1, z) - c2 + cell_at(x, y + 1, z);
               dz = cell_at(x, y, z - 1) - c2 + cell_at(x, y, z + 1);
               total = scaled_term(dx, cfg_inv[0]) + scaled_term(dy, cfg_inv[1]) +
                       scaled_term(dz, cfg_inv[2]);
               if (total > VALUE_MAX) begin
                  total = VALUE_MAX;
                  r.sat = 1'b1;
               end else if (total < VALUE_MIN) begin
                  total = VALUE_MIN;
                  r.sat = 1'b1;
               end
               r.value = total[DATA_BITS-1:0];
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   // result side stalls
   always @(posedge clock) begin
      if (reset || !rsp_stalls_on) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall <= 1'b0;
         stall_left = pick_gap();
      end
   end

   // compare each accepted result beat with the oldest expectation
   task automatic check_response();
      grid_response_type want;
      if (pending_responses.size() == 0) begin
         $error("result beat with nothing pending: result_value %0d", rsp_result_value);
         error_count++;
      end else begin
         want = pending_responses.pop_front();
         if (rsp_result_value !== want.value) begin
            $error("result_value: expected %0d, got %0d", want.value, rsp_result_value);
            error_count++;
         end
         if (rsp_bad_index !== want.bad) begin
            $error("bad_index: expected %0d, got %0d", want.bad, rsp_bad_index);
            error_count++;
         end
         if (rsp_saturated !== want.sat) begin
            $error("saturated: expected %0d, got %0d", want.sat, rsp_saturated);
            error_count++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) check_response();
   end

   // one request beat, with an optional gap ahead of it
   task automatic send_item(input logic [OP_BITS-1:0] op, input logic [POS_BITS-1:0] x,
                            input logic [POS_BITS-1:0] y, input logic [POS_BITS-1:0] z,
                            input logic [DATA_BITS-1:0] wv);
      int gap;
      grid_response_type next_rsp;
      gap = req_gaps_on ? pick_gap() : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_opcode      <= op;
      req_pos_x       <= x;
      req_pos_y       <= y;
      req_pos_z       <= z;
      req_write_value <= wv;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      next_rsp = compute_response(op, x, y, z, wv);
      pending_responses.insert(pending_responses.size(), next_rsp);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_responses.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CSR_DATA_BITS-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_data         <= data;
      @(posedge clock);
      case (idx)
         CSR_EXTENT_X: cfg_extent[0] = data[EXT_BITS-1:0];
         CSR_EXTENT_Y: cfg_extent[1] = data[EXT_BITS-1:0];
         CSR_EXTENT_Z: cfg_extent[2] = data[EXT_BITS-1:0];
         CSR_INV_X:    cfg_inv[0] = data;
         CSR_INV_Y:    cfg_inv[1] = data;
         CSR_INV_Z:    cfg_inv[2] = data;
         default: ;
      endcase
   endtask

   // all six registers; extents carry junk in the unused upper bits
   task automatic apply_config(input logic [EXT_BITS-1:0] ex, input logic [EXT_BITS-1:0] ey,
                               input logic [EXT_BITS-1:0] ez, input logic [INV_BITS-1:0] ix,
                               input logic [INV_BITS-1:0] iy, input logic [INV_BITS-1:0] iz);
      write_csr(CSR_EXTENT_X, {27'($urandom()), ex});
      write_csr(CSR_EXTENT_Y, {27'($urandom()), ey});
      write_csr(CSR_EXTENT_Z, {27'($urandom()), ez});
      write_csr(CSR_INV_X, ix);
      write_csr(CSR_INV_Y, iy);
      write_csr(CSR_INV_Z, iz);
      csr_write_enable <= 1'b0;
   endtask

   // position anywhere in the grid, mostly inside a small window
   function automatic logic [POS_BITS-1:0] pick_grid_pos(int ext, int lo);
      if ($urandom_range(0, 6) == 0) return POS_BITS'($urandom_range(0, ext + 1));
      return POS_BITS'($urandom_range(lo, (lo + 3 > ext + 1) ? ext + 1 : lo + 3));
   endfunction

   // interior position, mostly inside the window
   function automatic logic [POS_BITS-1:0] pick_inner_pos(int ext, int lo);
      int a, b;
      a = (lo < 1) ? 1 : lo;
      b = (lo + 3 > ext) ? ext : lo + 3;
      if (ext == 0) return POS_BITS'($urandom_range(0, 31));
      if (a > b || $urandom_range(0, 6) == 0) return POS_BITS'($urandom_range(1, ext));
      return POS_BITS'($urandom_range(a, b));
   endfunction

   // cleared store: zeros at the halo corners and around an interior cell, and the spare opcode
   task automatic test_cleared_grid();
      apply_config(30, 30, 30, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
      send_item(OP_READ, 0, 0, 0, 0);
      send_item(OP_READ, 31, 31, 31, 0);
      send_item(OP_LAPLACE, 30, 30, 30, 0);
      send_item(OP_SPARE, 31, 31, 31, 32'hFFFF_FFFF);
      wait_drained();
   endtask

   // extreme cell values clamp the sum both ways
   task automatic test_saturation();
      send_item(OP_WRITE, 5, 5, 5, 32'h7FFF_FFFF);
      send_item(OP_WRITE, 5, 5, 6, 32'h8000_0000);
      send_item(OP_LAPLACE, 5, 5, 5, 0);
      send_item(OP_READ, 5, 5, 6, 0);
      send_item(OP_WRITE, 10, 10, 10, 32'h8000_0000);
      send_item(OP_LAPLACE, 10, 10, 10, 0);
      wait_drained();
   endtask

   // halo neighbours, interior edges, extent above max, writes out of grid
   task automatic test_halo_and_bounds();
      apply_config(1, 2, 31, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
      send_item(OP_WRITE, 0, 1, 1, 32'h0003_0000);
      send_item(OP_LAPLACE, 1, 1, 1, 0);
      send_item(OP_LAPLACE, 0, 1, 1, 0);
      send_item(OP_LAPLACE, 2, 1, 1, 0);
      send_item(OP_LAPLACE, 1, 2, 30, 0);
      send_item(OP_WRITE, 3, 1, 1, 32'h1234_5678);
      send_item(OP_READ, 2, 3, 31, 0);
      send_item(OP_READ, 2, 4, 1, 0);
      wait_drained();
   endtask

   // zero extents: halo only, nothing interior
   task automatic test_empty_interior();
      apply_config(0, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_item(OP_LAPLACE, 1, 1, 1, 0);
      send_item(OP_READ, 1, 1, 1, 0);
      send_item(OP_WRITE, 1, 0, 1, 32'hFFFF_FFFF);
      send_item(OP_READ, 2, 0, 0, 0);
      wait_drained();
   endtask

   // half-lsb rounding of the scaled term, and the ignored write stays out
   task automatic test_rounding();
      apply_config(30, 30, 30, 32'd1, 32'd0, 32'hFFFF_FFFF);
      send_item(OP_READ, 3, 1, 1, 0);
      send_item(OP_WRITE, 19, 20, 20, 32'h0000_8000);
      send_item(OP_LAPLACE, 20, 20, 20, 0);
      send_item(OP_WRITE, 19, 20, 20, 32'hFFFF_8000);
      send_item(OP_LAPLACE, 20, 20, 20, 0);
      send_item(OP_WRITE, 19, 20, 20, 32'hFFFF_7FFF);
      send_item(OP_LAPLACE, 20, 20, 20, 0);
      wait_drained();
   endtask

   // random traffic in phases of different settings
   task automatic test_random_phases();
      int lo [3];
      int ext [3];
      int roll;
      logic [DATA_BITS-1:0] wv;
      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: apply_config(30, 30, 30, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
            1: apply_config(1, 1, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
            2: apply_config(31, 31, 31, 32'd0, 32'd0, 32'd0);
            3: apply_config(0, 5, 7, $urandom(), $urandom(), $urandom());
            5: apply_config(EXT_BITS'($urandom_range(1, 31)), EXT_BITS'($urandom_range(1, 31)),
                            EXT_BITS'($urandom_range(1, 31)), $urandom_range(0, 32'h3FFFF),
                            $urandom_range(0, 32'h3FFFF), $urandom_range(0, 32'h3FFFF));
            6: apply_config(30, 2, 17, $urandom(), $urandom(), $urandom());
            default: apply_config(EXT_BITS'($urandom_range(1, 31)),
                                  EXT_BITS'($urandom_range(1, 31)),
                                  EXT_BITS'($urandom_range(1, 31)), $urandom(), $urandom(),
                                  $urandom());
         endcase
         req_gaps_on   = (phase != 4 && phase != 6);
         rsp_stalls_on = (phase != 4);
         // small window so laplacians see written neighbours
         foreach (ext[a]) begin
            ext[a] = clamp_extent(cfg_extent[a]);
            lo[a]  = $urandom_range(0, (ext[a] + 1 > 3) ? ext[a] - 2 : 0);
         end
         repeat (PHASE_ITEMS) begin
            case ($urandom_range(0, 3))
               0: wv = $urandom();
               1: wv = $urandom_range(0, 32'h7FFFF) - 32'h40000;
               2: wv = '0;
               default: wv = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            endcase
            roll = $urandom_range(0, 99);
            if (roll < 35)
               send_item(OP_WRITE, pick_grid_pos(ext[0], lo[0]), pick_grid_pos(ext[1], lo[1]),
                         pick_grid_pos(ext[2], lo[2]), wv);
            else if (roll < 55)
               send_item(OP_READ, pick_grid_pos(ext[0], lo[0]), pick_grid_pos(ext[1], lo[1]),
                         pick_grid_pos(ext[2], lo[2]), wv);
            else if (roll < 90)
               send_item(OP_LAPLACE, pick_inner_pos(ext[0], lo[0]),
                         pick_inner_pos(ext[1], lo[1]), pick_inner_pos(ext[2], lo[2]), wv);
            else
               send_item(2'($urandom_range(0, 3)), 5'($urandom()), 5'($urandom()),
                         5'($urandom()), $urandom());
         end
         wait_drained();
      end
   endtask

   // test sequence
   initial begin
      clear_grid_model();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_cleared_grid();
      test_saturation();
      test_halo_and_bounds();
      test_empty_interior();
      test_rounding();
      test_random_phases();
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("tb_grid_laplacian_7pt: done, clean");
      else
         $display("tb_grid_laplacian_7pt: done, errors");
      $finish;
   end

endmodule
